[hdl/scdb_pkg.sv]
package scdb_pkg;

  // Default sizes of the grid and of the azimuth result.
  localparam int unsigned MaxRingsDef   = 32;
  localparam int unsigned MaxSectorsDef = 64;
  localparam int unsigned AngleBitsDef  = 16;

  // Operation codes.
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_POINT   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_RADIUS   = 2'd0;
  localparam logic [1:0] REG_RING_COUNT   = 2'd1;
  localparam logic [1:0] REG_SECTOR_COUNT = 2'd2;

  // Configuration reset values.
  localparam logic [14:0] MAX_RADIUS_RST   = 15'd20480;
  localparam logic [5:0]  RING_COUNT_RST   = 6'd20;
  localparam logic [6:0]  SECTOR_COUNT_RST = 7'd60;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [4:0]         read_ring;
    logic [5:0]         read_sector;
  } item_t;

  typedef struct packed {
    logic signed [15:0] cell_value;
    logic               cell_occupied;
    logic               point_kept;
    logic [4:0]         bin_ring;
    logic [5:0]         bin_sector;
  } res_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [14:0] value;
  } cfg_t;

  // Arctangent of 2^-i in units of 2^-32 turns.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[hdl/scdb_chan_if.sv]
// Valid/ready channel carrying one payload per transfer.
interface scdb_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hdl/scan_context_descriptor_builder.sv]
// Polar max-height grid builder. Each input transfer carries one operation and
// yields exactly one result transfer; the next input is taken only after that
// result has moved into the output register, so a stalled result holds the input
// back. Clearing the grid sweeps the cell memory one entry per cycle; the same sweep
// runs after reset, and no operation is taken until it ends. A kept point runs the
// 32-step atan2 unit and the ring search (one ring per cycle) side by side, followed
// by a read-modify-write of the single cell memory. Configuration writes are always
// accepted, but may only be written while no operation is in progress.
module scan_context_descriptor_builder import scdb_pkg::*; #(
  parameter int unsigned MAX_RINGS   = MaxRingsDef,
  parameter int unsigned MAX_SECTORS = MaxSectorsDef,
  parameter int unsigned ANGLE_BITS  = AngleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scdb_chan_if.sink   pt_i,
  scdb_chan_if.source res_o,
  scdb_chan_if.sink   cfg_i
);

  localparam int unsigned CELLS = MAX_RINGS * MAX_SECTORS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned RW    = $clog2(MAX_RINGS + 1);
  localparam int unsigned SW    = $clog2(MAX_SECTORS + 1);
  localparam int unsigned PW    = ANGLE_BITS + SW + 1;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SQR   = 10'b0000000100,
    S_CHK   = 10'b0000001000,
    S_RUN   = 10'b0000010000,
    S_SEC   = 10'b0000100000,
    S_ADR   = 10'b0001000000,
    S_LOOK  = 10'b0010000000,
    S_UPD   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e          state_q;
  item_t           item_q;
  res_t            res_q, out_q, upd_res;
  logic            outv_q, clr_op_q, rdone_q, cdone_q, inrng_q;
  logic [AW-1:0]   cnt_q, addr_q;
  logic [14:0]     mr_q;
  logic [5:0]      rc_q;
  logic [6:0]      sc_q;
  logic [30:0]     xx_q, yy_q;
  logic [29:0]     rad2_q;
  logic [RW-1:0]   nr_q, nr_c, ring_k;
  logic [SW-1:0]   ns_q, ns_c, sec_c;
  logic [SW:0]     sec_raw;
  logic [PW-1:0]   prod_q;
  logic [4:0]      bring_q;
  logic [5:0]      bsec_q;
  logic [31:0]     r2;
  logic            keep, pt_fire, out_free, ring_done, cord_done, start_units, upd_new;
  logic [ANGLE_BITS-1:0] turns;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [16:0]     ram_wdata, ram_rdata;

  // Configuration registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mr_q <= MAX_RADIUS_RST;
      rc_q <= RING_COUNT_RST;
      sc_q <= SECTOR_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_MAX_RADIUS:   mr_q <= cfg_i.data.value;
        REG_RING_COUNT:   rc_q <= cfg_i.data.value[5:0];
        REG_SECTOR_COUNT: sc_q <= cfg_i.data.value[6:0];
        default: ;
      endcase
    end
  end

  // Counts clamped to the range 1 to the storage size.
  always_comb begin
    if (rc_q == '0) begin
      nr_c = RW'(1);
    end else if (32'(rc_q) > MAX_RINGS) begin
      nr_c = RW'(MAX_RINGS);
    end else begin
      nr_c = RW'(rc_q);
    end
    if (sc_q == '0) begin
      ns_c = SW'(1);
    end else if (32'(sc_q) > MAX_SECTORS) begin
      ns_c = SW'(MAX_SECTORS);
    end else begin
      ns_c = SW'(sc_q);
    end
  end

  // Range test, sector rounding and clamp.
  always_comb begin
    r2      = 32'(xx_q) + 32'(yy_q);
    keep    = (r2 <= 32'(rad2_q));
    sec_raw = prod_q[ANGLE_BITS +: SW+1];
    if (sec_raw == '0) begin
      sec_c = SW'(1);
    end else if (sec_raw > (SW+1)'(ns_q)) begin
      sec_c = ns_q;
    end else begin
      sec_c = SW'(sec_raw);
    end
  end

  assign pt_i.ready  = (state_q == S_IDLE);
  assign pt_fire     = pt_i.valid && pt_i.ready;
  assign out_free    = !outv_q || res_o.ready;
  assign start_units = (state_q == S_CHK) && keep;
  assign upd_new     = !ram_rdata[16] || (item_q.point_z > $signed(ram_rdata[15:0]));

  scdb_ring #(.MAX_RINGS(MAX_RINGS)) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_units),
    .nr_i   (nr_q),
    .r2_i   (r2[29:0]),
    .rad2_i (rad2_q),
    .done_o (ring_done),
    .ring_o (ring_k)
  );

  scdb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_units),
    .x_i    (item_q.point_x),
    .y_i    (item_q.point_y),
    .done_o (cord_done),
    .turns_o(turns)
  );

  // Memory port control: the clearing sweep and the cell update share the write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = {1'b1, item_q.point_z};
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q;
      ram_wdata = '0;
    end else if (state_q == S_UPD && item_q.op == OP_POINT && upd_new) begin
      ram_we = 1'b1;
    end
    ram_re    = (state_q == S_LOOK);
    ram_raddr = addr_q;
  end

  scdb_ram #(.WIDTH(17), .DEPTH(CELLS)) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result of a point or a read once the cell word is back from memory.
  always_comb begin
    upd_res = '0;
    if (item_q.op == OP_POINT) begin
      upd_res.point_kept = 1'b1;
      upd_res.bin_ring   = bring_q;
      upd_res.bin_sector = bsec_q;
    end else if (inrng_q && ram_rdata[16]) begin
      upd_res.cell_value    = ram_rdata[15:0];
      upd_res.cell_occupied = 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      clr_op_q <= 1'b0;
      outv_q   <= 1'b0;
      rdone_q  <= 1'b0;
      cdone_q  <= 1'b0;
    end else begin
      if (outv_q && res_o.ready && state_q != S_OUT) begin
        outv_q <= 1'b0;
      end
      if (ring_done) begin
        rdone_q <= 1'b1;
      end
      if (cord_done) begin
        cdone_q <= 1'b1;
      end
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == AW'(CELLS - 1)) begin
            state_q <= clr_op_q ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (pt_fire) begin
            case (pt_i.data.op)
              OP_CLEAR: begin
                cnt_q    <= '0;
                clr_op_q <= 1'b1;
                state_q  <= S_CLEAR;
              end
              OP_POINT: state_q <= S_SQR;
              OP_READ:  state_q <= S_LOOK;
              default:  state_q <= S_OUT;
            endcase
          end
        end
        S_SQR: state_q <= S_CHK;
        S_CHK: begin
          rdone_q <= 1'b0;
          cdone_q <= 1'b0;
          state_q <= keep ? S_RUN : S_OUT;
        end
        S_RUN: begin
          if (rdone_q && cdone_q) begin
            state_q <= S_SEC;
          end
        end
        S_SEC:  state_q <= S_ADR;
        S_ADR:  state_q <= S_LOOK;
        S_LOOK: state_q <= S_UPD;
        S_UPD:  state_q <= S_OUT;
        S_OUT: begin
          // A result still waiting is taken in this cycle when out_free is set.
          if (out_free) begin
            outv_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CLEAR: begin
        res_q <= '0;
      end
      S_IDLE: begin
        if (pt_fire) begin
          item_q  <= pt_i.data;
          res_q   <= '0;
          addr_q  <= AW'(32'(pt_i.data.read_ring) * 32'(MAX_SECTORS)
                         + 32'(pt_i.data.read_sector));
          inrng_q <= (32'(pt_i.data.read_ring) < MAX_RINGS)
                     && (32'(pt_i.data.read_sector) < MAX_SECTORS);
        end
      end
      S_SQR: begin
        xx_q   <= 31'(32'(item_q.point_x) * 32'(item_q.point_x));
        yy_q   <= 31'(32'(item_q.point_y) * 32'(item_q.point_y));
        rad2_q <= 30'(mr_q) * 30'(mr_q);
        nr_q   <= nr_c;
        ns_q   <= ns_c;
      end
      S_SEC: begin
        prod_q <= PW'(turns) * PW'(ns_q) + PW'((1 << ANGLE_BITS) - 1);
      end
      S_ADR: begin
        addr_q  <= AW'((32'(ring_k) - 32'd1) * 32'(MAX_SECTORS) + 32'(sec_c) - 32'd1);
        bring_q <= 5'(32'(ring_k) - 32'd1);
        bsec_q  <= 6'(32'(sec_c) - 32'd1);
        inrng_q <= 1'b1;
      end
      S_UPD: begin
        res_q <= upd_res;
      end
      S_OUT: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid = outv_q;
  assign res_o.data  = out_q;

  cell_write_only_for_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && ram_we) |-> (item_q.op == OP_POINT))
    else $error("cell written by an operation other than add point");

  point_result_has_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.point_kept) |-> !res_o.data.cell_occupied)
    else $error("result mixes point and read fields");

  reset_sweep_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && cnt_q == AW'(CELLS - 1) && !clr_op_q) |=> (state_q == S_IDLE))
    else $error("reset sweep did not return to idle");

  run_waits_for_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && !(rdone_q && cdone_q)) |=> (state_q == S_RUN))
    else $error("binning left before ring and angle were ready");

endmodule

[hdl/scdb_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module scdb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hdl/scdb_cordic.sv]
// Iterative vectoring CORDIC: one micro-rotation per cycle, with done raised in the
// cycle after the last one.
module scdb_cordic import scdb_pkg::*; #(
  parameter int unsigned ANGLE_BITS = AngleBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [15:0]    x_i,
  input  logic signed [15:0]    y_i,
  output logic                  done_o,
  output logic [ANGLE_BITS-1:0] turns_o
);

  localparam int unsigned CW = 40;

  logic                 busy_q;
  logic                 done_q;
  logic [4:0]           it_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [CW-1:0] dx, dy;
  logic signed [16:0]   sx, sy;
  logic [31:0]          acc_q;
  logic [32:0]          rnd;

  // Shifted operands and the half-turn pre-rotation for the left half plane.
  always_comb begin
    dx = cx_q >>> it_q;
    dy = cy_q >>> it_q;
    sx = x_i[15] ? -17'(x_i) : 17'(x_i);
    sy = x_i[15] ? -17'(y_i) : 17'(y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      // The origin finishes at once; other points after the last micro-rotation.
      done_q <= start_i ? (x_i == 16'sd0 && y_i == 16'sd0) : (busy_q && it_q == 5'd31);
      if (start_i) begin
        it_q <= '0;
        if (!(x_i == 16'sd0 && y_i == 16'sd0)) begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        it_q <= it_q + 5'd1;
        if (it_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: rotate toward the x axis and accumulate the angle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cx_q  <= CW'(sx) <<< 20;
      cy_q  <= CW'(sy) <<< 20;
      acc_q <= x_i[15] ? 32'h80000000 : 32'h0;
    end else if (busy_q) begin
      if (!cy_q[CW-1]) begin
        cx_q  <= cx_q + dy;
        cy_q  <= cy_q - dx;
        acc_q <= acc_q + atan_turn(it_q);
      end else begin
        cx_q  <= cx_q - dy;
        cy_q  <= cy_q + dx;
        acc_q <= acc_q - atan_turn(it_q);
      end
    end
  end

  // Round half up to the output resolution, wrapping at a full turn.
  assign rnd     = {1'b0, acc_q} + (33'd1 << (31 - ANGLE_BITS));
  assign turns_o = rnd[31 -: ANGLE_BITS];
  assign done_o  = done_q;

endmodule

[hdl/scdb_ring.sv]
// Ring search: steps k upward, keeping k^2 * radius^2 by running sums.
module scdb_ring import scdb_pkg::*; #(
  parameter int unsigned MAX_RINGS = MaxRingsDef,
  localparam int unsigned RW = $clog2(MAX_RINGS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [RW-1:0] nr_i,
  input  logic [29:0]   r2_i,
  input  logic [29:0]   rad2_i,
  output logic          done_o,
  output logic [RW-1:0] ring_o
);

  localparam int unsigned PW = 30 + 2 * RW;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_MUL  = 3'b010,
    R_SRCH = 3'b100
  } ring_state_e;

  ring_state_e       state_q;
  logic              done_q;
  logic [RW-1:0]     nr_q, k_q;
  logic [2*RW-1:0]   nsq_q;
  logic [29:0]       r2_q;
  logic [PW-1:0]     lhs_q, acc_q, dlt_q, two_q;
  logic              srch_end;

  // The search stops at the first ring that holds the point, or at the last ring.
  assign srch_end = (32'(k_q) >= 32'(nr_q)) || (lhs_q <= acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == R_SRCH) && srch_end;
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            state_q <= R_MUL;
          end
        end
        R_MUL: begin
          state_q <= R_SRCH;
        end
        R_SRCH: begin
          if (srch_end) begin
            state_q <= R_IDLE;
          end
        end
        default: begin
          state_q <= R_IDLE;
        end
      endcase
    end
  end

  // Datapath: N^2 * r2 once, then (k+1)^2 R^2 = k^2 R^2 + (2k+1) R^2 per step.
  always_ff @(posedge clk_i) begin
    if (state_q == R_IDLE && start_i) begin
      nr_q  <= nr_i;
      nsq_q <= (2*RW)'(nr_i) * (2*RW)'(nr_i);
      r2_q  <= r2_i;
      k_q   <= RW'(1);
      acc_q <= PW'(rad2_i);
      dlt_q <= PW'(rad2_i) + PW'({rad2_i, 1'b0});
      two_q <= PW'({rad2_i, 1'b0});
    end else if (state_q == R_MUL) begin
      lhs_q <= PW'(nsq_q) * PW'(r2_q);
    end else if (state_q == R_SRCH) begin
      if (!srch_end) begin
        k_q   <= k_q + RW'(1);
        acc_q <= acc_q + dlt_q;
        dlt_q <= dlt_q + two_q;
      end
    end
  end

  assign done_o = done_q;
  assign ring_o = k_q;

  ring_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (k_q <= nr_q && k_q != '0))
    else $error("ring result outside 1..ring count");

endmodule
